// ===== rtl/core/bpnm_pkg.sv =====
// Package for the bit-parallel NFA matcher: item structs, codes and defaults.
// Used by every module in rtl/core; depends on nothing else.
package bpnm_pkg;

  localparam int STATE_BITS_DEF  = 64;
  localparam int MAX_LEVELS_DEF  = 8;
  localparam int SHIFT_STEPS_DEF = 6;
  localparam int CFG_DATA_W      = 6;

  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_START    = 2'd1;
  localparam logic [1:0] KIND_SYMBOL   = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [3:0] SEL_CHAR     = 4'd0;
  localparam logic [3:0] SEL_LOOP     = 4'd1;
  localparam logic [3:0] SEL_GATH_BLK = 4'd2;
  localparam logic [3:0] SEL_GATH_SRC = 4'd3;
  localparam logic [3:0] SEL_GATH_DST = 4'd4;
  localparam logic [3:0] SEL_SCAT_BLK = 4'd5;
  localparam logic [3:0] SEL_SCAT_SRC = 4'd6;
  localparam logic [3:0] SEL_SCAT_DST = 4'd7;
  localparam logic [3:0] SEL_PROP_BLK = 4'd8;
  localparam logic [3:0] SEL_PROP_SRC = 4'd9;
  localparam logic [3:0] SEL_PROP_DST = 4'd10;
  localparam logic [3:0] SEL_BACK_SRC = 4'd11;
  localparam logic [3:0] SEL_BACK_DST = 4'd12;
  localparam logic [3:0] SEL_BACK_BLK = 4'd13;

  localparam logic CFG_LEVEL_COUNT  = 1'b0;
  localparam logic CFG_ACCEPT_INDEX = 1'b1;

  typedef enum logic [1:0] {OP_PROP, OP_BACK, OP_GATH, OP_SCAT} op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  table_select;
    logic [7:0]  table_row;
    logic [2:0]  shift_level;
    logic [63:0] table_word;
    logic [7:0]  symbol;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic [31:0] position;
  } out_item_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  sel;
    logic [7:0]  row;
    logic [2:0]  step;
    logic [63:0] word;
  } tbl_wr_t;

endpackage

// ===== rtl/core/bpnm_char_mem.sv =====
// Symbol and self-loop mask memories, 256 rows each, one registered read port.
// Depends on bpnm_pkg.
module bpnm_char_mem #(
  parameter int SB = 64
) (
  input  logic             clk,
  input  bpnm_pkg::tbl_wr_t wr,
  input  logic [7:0]       rd_addr,
  output logic [SB-1:0]    sym_q,
  output logic [SB-1:0]    loop_q
);
  import bpnm_pkg::*;

  logic [SB-1:0] sym_mem  [256];
  logic [SB-1:0] loop_mem [256];

  always_ff @(posedge clk) begin
    if (wr.we && wr.sel == SEL_CHAR) begin
      sym_mem[wr.row] <= wr.word[SB-1:0];
    end
    if (wr.we && wr.sel == SEL_LOOP) begin
      loop_mem[wr.row] <= wr.word[SB-1:0];
    end
    sym_q  <= sym_mem[rd_addr];
    loop_q <= loop_mem[rd_addr];
  end

endmodule

// ===== rtl/core/bpnm_level_mem.sv =====
// Per-level closure mask memories (propagate, gather, scatter, back edge),
// all read at one level address with registered outputs. Depends on bpnm_pkg.
module bpnm_level_mem #(
  parameter int SB  = 64,
  parameter int ML  = 8,
  parameter int SS  = 6,
  parameter int LIW = 3
) (
  input  logic              clk,
  input  bpnm_pkg::tbl_wr_t wr,
  input  logic [LIW-1:0]    rd_addr,
  output logic [SB-1:0]     prop_q [3],
  output logic [SB-1:0]     gath_q [3],
  output logic [SB-1:0]     scat_q [3],
  output logic [SB-1:0]     bsrc_q,
  output logic [SB-1:0]     bdst_q,
  output logic [SB-1:0]     bblk_q [SS]
);
  import bpnm_pkg::*;

  logic [SB-1:0] prop_mem [3][ML];
  logic [SB-1:0] gath_mem [3][ML];
  logic [SB-1:0] scat_mem [3][ML];
  logic [SB-1:0] bsrc_mem [ML];
  logic [SB-1:0] bdst_mem [ML];
  logic [SB-1:0] bblk_mem [SS][ML];

  logic           row_ok;
  logic [LIW-1:0] wa;
  logic [SB-1:0]  wd;

  assign row_ok = wr.we && (wr.row < 8'(ML));
  assign wa     = wr.row[LIW-1:0];
  assign wd     = wr.word[SB-1:0];

  always_ff @(posedge clk) begin
    if (row_ok) begin
      case (wr.sel)
        SEL_GATH_BLK: gath_mem[0][wa] <= wd;
        SEL_GATH_SRC: gath_mem[1][wa] <= wd;
        SEL_GATH_DST: gath_mem[2][wa] <= wd;
        SEL_SCAT_BLK: scat_mem[0][wa] <= wd;
        SEL_SCAT_SRC: scat_mem[1][wa] <= wd;
        SEL_SCAT_DST: scat_mem[2][wa] <= wd;
        SEL_PROP_BLK: prop_mem[0][wa] <= wd;
        SEL_PROP_SRC: prop_mem[1][wa] <= wd;
        SEL_PROP_DST: prop_mem[2][wa] <= wd;
        SEL_BACK_SRC: bsrc_mem[wa] <= wd;
        SEL_BACK_DST: bdst_mem[wa] <= wd;
        SEL_BACK_BLK: begin
          if (wr.step < 3'(SS)) begin
            bblk_mem[wr.step][wa] <= wd;
          end
        end
        default: ;
      endcase
    end
    for (int j = 0; j < 3; j++) begin
      prop_q[j] <= prop_mem[j][rd_addr];
      gath_q[j] <= gath_mem[j][rd_addr];
      scat_q[j] <= scat_mem[j][rd_addr];
    end
    bsrc_q <= bsrc_mem[rd_addr];
    bdst_q <= bdst_mem[rd_addr];
    for (int i = 0; i < SS; i++) begin
      bblk_q[i] <= bblk_mem[i][rd_addr];
    end
  end

endmodule

// ===== rtl/core/bpnm_closure_alu.sv =====
// One closure step on the state vector: propagate, back edge, gather or scatter.
// Depends on bpnm_pkg.
module bpnm_closure_alu #(
  parameter int SB = 64,
  parameter int SS = 6
) (
  input  bpnm_pkg::op_t  op,
  input  logic [SB-1:0]  st,
  input  logic [SB-1:0]  prop_q [3],
  input  logic [SB-1:0]  gath_q [3],
  input  logic [SB-1:0]  scat_q [3],
  input  logic [SB-1:0]  bsrc_q,
  input  logic [SB-1:0]  bdst_q,
  input  logic [SB-1:0]  bblk_q [SS],
  output logic [SB-1:0]  st_nxt
);
  import bpnm_pkg::*;

  logic [SB-1:0] pa, pd, acc;

  always_comb begin
    pa     = prop_q[2] | (st & prop_q[0]);
    pd     = pa - prop_q[1];
    acc    = st & bsrc_q;
    st_nxt = st;
    case (op)
      OP_PROP: st_nxt = st | (prop_q[0] & (~pd ^ pa));
      OP_GATH: st_nxt = st | ((gath_q[0] + (st & gath_q[1])) & gath_q[2]);
      OP_SCAT: st_nxt = st | ((scat_q[0] - (st & scat_q[1])) & scat_q[2]);
      OP_BACK: begin
        // Log shifter: each stage moves the selected bits down by a power of two.
        for (int i = 0; i < SS; i++) begin
          acc = (acc & ~bblk_q[i]) | ((acc & bblk_q[i]) >> (1 << i));
        end
        st_nxt = st | (acc & bdst_q);
      end
      default: st_nxt = st;
    endcase
  end

endmodule

// ===== rtl/core/bit_parallel_nfa_matcher.sv =====
// Bit-parallel NFA matcher. A start request goes straight to the closure; a
// symbol request first takes the shift-and step. The closure sequencer applies
// one mask step per cycle from the level memories. The input is ready again as
// the result appears, so a new request is taken only once the last one's result
// is issued, and that waits while an earlier result is held. Table writes give
// no result. Reset clears the state vector, position and handshakes and sets the
// configuration to its defaults; mask memories hold garbage until written.
module bit_parallel_nfa_matcher #(
  parameter int STATE_BITS  = bpnm_pkg::STATE_BITS_DEF,
  parameter int MAX_LEVELS  = bpnm_pkg::MAX_LEVELS_DEF,
  parameter int SHIFT_STEPS = bpnm_pkg::SHIFT_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bpnm_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bpnm_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [bpnm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bpnm_pkg::*;

  localparam int SB  = STATE_BITS;
  localparam int LIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LCW = $clog2(MAX_LEVELS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_CLOSE, S_FIN} state_t;
  typedef enum logic {PH_DOWN, PH_UP} phase_t;

  state_t         state_r, state_nxt;
  phase_t         phase_r, phase_nxt;
  logic [LIW-1:0] k_r, k_nxt;
  logic [1:0]     sub_r, sub_nxt;
  logic           done_r, done_nxt;
  logic           pend_r, pend_nxt;
  op_t            pop_r, pop_nxt;
  logic [SB-1:0]  st_r, st_nxt;
  logic [31:0]    pos_r, pos_nxt;
  logic [3:0]     lvl_cfg_r;
  logic [5:0]     acc_idx_r;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  logic [LCW-1:0] lcount;
  logic [LIW-1:0] k_top;
  op_t            iss_op;
  logic [LIW-1:0] iss_lv;
  logic           accept;
  tbl_wr_t        wr;
  logic [SB-1:0]  sym_q, loop_q, alu_out;
  logic [SB-1:0]  prop_q [3];
  logic [SB-1:0]  gath_q [3];
  logic [SB-1:0]  scat_q [3];
  logic [SB-1:0]  bsrc_q, bdst_q;
  logic [SB-1:0]  bblk_q [SHIFT_STEPS];
  logic           matched;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (lvl_cfg_r == 4'd0) begin
      lcount = LCW'(1);
    end else if ({28'd0, lvl_cfg_r} > MAX_LEVELS) begin
      lcount = LCW'(MAX_LEVELS);
    end else begin
      lcount = LCW'(lvl_cfg_r);
    end
    k_top = LIW'(lcount - LCW'(1));
  end

  always_comb begin
    wr.we   = accept && (in_data.kind == KIND_WRITE);
    wr.sel  = in_data.table_select;
    wr.row  = in_data.table_row;
    wr.step = in_data.shift_level;
    wr.word = in_data.table_word;
  end

  // Operation issued this cycle; its masks arrive next cycle.
  always_comb begin
    iss_op = OP_PROP;
    iss_lv = k_r;
    case (phase_r)
      PH_DOWN: begin
        case (sub_r)
          2'd0: iss_op = OP_PROP;
          2'd1: iss_op = OP_BACK;
          default: begin
            iss_op = OP_GATH;
            iss_lv = k_r - LIW'(1);
          end
        endcase
      end
      default: begin
        if (sub_r == 2'd0) begin
          iss_op = OP_SCAT;
          iss_lv = k_r - LIW'(1);
        end else begin
          iss_op = OP_PROP;
        end
      end
    endcase
  end

  bpnm_char_mem #(.SB(SB)) u_char (
    .clk(clk), .wr(wr), .rd_addr(in_data.symbol), .sym_q(sym_q), .loop_q(loop_q)
  );

  bpnm_level_mem #(.SB(SB), .ML(MAX_LEVELS), .SS(SHIFT_STEPS), .LIW(LIW)) u_lvl (
    .clk(clk), .wr(wr), .rd_addr(iss_lv), .prop_q(prop_q), .gath_q(gath_q),
    .scat_q(scat_q), .bsrc_q(bsrc_q), .bdst_q(bdst_q), .bblk_q(bblk_q)
  );

  bpnm_closure_alu #(.SB(SB), .SS(SHIFT_STEPS)) u_alu (
    .op(pop_r), .st(st_r), .prop_q(prop_q), .gath_q(gath_q), .scat_q(scat_q),
    .bsrc_q(bsrc_q), .bdst_q(bdst_q), .bblk_q(bblk_q), .st_nxt(alu_out)
  );

  assign matched = ({26'd0, acc_idx_r} < SB) ? st_r[acc_idx_r[$clog2(SB)-1:0]] : 1'b0;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    k_nxt         = k_r;
    sub_nxt       = sub_r;
    done_nxt      = done_r;
    pend_nxt      = 1'b0;
    pop_nxt       = pop_r;
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        phase_nxt = PH_DOWN;
        k_nxt     = k_top;
        sub_nxt   = 2'd0;
        done_nxt  = 1'b0;
        if (accept && in_data.kind == KIND_START) begin
          st_nxt    = {{(SB-1){1'b0}}, 1'b1};
          pos_nxt   = 32'd0;
          state_nxt = S_CLOSE;
        end else if (accept && in_data.kind == KIND_SYMBOL) begin
          pos_nxt   = (pos_r == 32'hFFFF_FFFF) ? pos_r : pos_r + 32'd1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        st_nxt    = ((st_r << 1) & sym_q) | {{(SB-1){1'b0}}, 1'b1} | (st_r & loop_q);
        state_nxt = S_CLOSE;
      end
      S_CLOSE: begin
        if (pend_r) begin
          st_nxt = alu_out;
        end
        if (!done_r) begin
          pend_nxt = 1'b1;
          pop_nxt  = iss_op;
          case (phase_r)
            PH_DOWN: begin
              if (sub_r == 2'd0) begin
                sub_nxt = 2'd1;
              end else if (sub_r == 2'd1) begin
                if (k_r == '0) begin
                  if (lcount == LCW'(1)) begin
                    done_nxt = 1'b1;
                  end else begin
                    phase_nxt = PH_UP;
                    k_nxt     = LIW'(1);
                    sub_nxt   = 2'd0;
                  end
                end else begin
                  sub_nxt = 2'd2;
                end
              end else begin
                k_nxt   = k_r - LIW'(1);
                sub_nxt = 2'd0;
              end
            end
            default: begin
              if (sub_r == 2'd0) begin
                sub_nxt = 2'd1;
              end else if ({1'b0, k_r} + (LIW+1)'(1) == (LIW+1)'(lcount)) begin
                done_nxt = 1'b1;
              end else begin
                k_nxt   = k_r + LIW'(1);
                sub_nxt = 2'd0;
              end
            end
          endcase
        end else if (!pend_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.matched  = matched;
          out_data_nxt.position = pos_r;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_DOWN;
      k_r         <= '0;
      sub_r       <= 2'd0;
      done_r      <= 1'b0;
      pend_r      <= 1'b0;
      st_r        <= '0;
      pos_r       <= 32'd0;
      lvl_cfg_r   <= 4'd1;
      acc_idx_r   <= 6'd63;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      sub_r       <= sub_nxt;
      done_r      <= done_nxt;
      pend_r      <= pend_nxt;
      st_r        <= st_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_LEVEL_COUNT) begin
        lvl_cfg_r <= cfg_data[3:0];
      end
      if (cfg_we && cfg_index == CFG_ACCEPT_INDEX) begin
        acc_idx_r <= cfg_data[5:0];
      end
    end
    pop_r      <= pop_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/core/bpnm_checker.sv =====
// Port-level checks for the NFA matcher, bound to the top level.
// Depends on bpnm_pkg and bit_parallel_nfa_matcher.
module bpnm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input bpnm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input bpnm_pkg::out_item_t out_data
);
  import bpnm_pkg::*;

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A start or symbol request keeps the block busy for the closure.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.kind == KIND_START || in_data.kind == KIND_SYMBOL)
    |=> !in_ready)
    else $error("block ready straight after a match request");

  // A table write never raises a result.
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == KIND_WRITE && !out_valid |=> !out_valid)
    else $error("table write produced a result");

  // A table write leaves the block ready for the next request.
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == KIND_WRITE |=> in_ready)
    else $error("block stalled after a table write");

endmodule

bind bit_parallel_nfa_matcher bpnm_checker u_bpnm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== test/nfa_match_checker.sv =====
// Watches the request and result channels of the NFA matcher, predicts each
// result with its own shift-and and closure model, and counts mismatches.
// Depends on bpnm_pkg.
`timescale 1ns / 1ps
module nfa_match_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bpnm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bpnm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_data,
  output int                  fail_count,
  output int                  pending_count
);
  import bpnm_pkg::*;

  localparam int NLV = MAX_LEVELS_DEF;
  localparam int NSH = SHIFT_STEPS_DEF;

  logic [3:0]  levels_reg;
  logic [5:0]  accept_bit;
  logic [63:0] nfa_states;
  logic [31:0] text_pos;
  logic [63:0] sym_tab [256];
  logic [63:0] loop_tab [256];
  logic [63:0] gath_tab [3*NLV];
  logic [63:0] scat_tab [3*NLV];
  logic [63:0] prop_tab [3*NLV];
  logic [63:0] bsrc_tab [NLV];
  logic [63:0] bdst_tab [NLV];
  logic [63:0] bblk_tab [NLV*NSH];
  out_item_t   match_queue [$];

  assign pending_count = match_queue.size();

  function automatic logic [63:0] propagate_step(logic [63:0] s, int lv);
    logic [63:0] a, d, blk;
    blk = prop_tab[3*lv];
    a = prop_tab[3*lv+2] | (s & blk);
    d = a - prop_tab[3*lv+1];
    return s | (blk & (~d ^ a));
  endfunction

  function automatic logic [63:0] back_step(logic [63:0] s, int lv);
    logic [63:0] a, blk;
    a = s & bsrc_tab[lv];
    for (int i = 0; i < NSH; i++) begin
      blk = bblk_tab[lv*NSH+i];
      a = (a & ~blk) | ((a & blk) >> (1 << i));
    end
    return s | (a & bdst_tab[lv]);
  endfunction

  function automatic logic [63:0] epsilon_closure(logic [63:0] s);
    int n;
    n = (levels_reg == 0) ? 1 : (levels_reg > NLV ? NLV : int'(levels_reg));
    for (int k = n - 1; k >= 1; k--) begin
      s = propagate_step(s, k);
      s = back_step(s, k);
      s = s | ((gath_tab[3*(k-1)] + (s & gath_tab[3*(k-1)+1])) & gath_tab[3*(k-1)+2]);
    end
    s = propagate_step(s, 0);
    s = back_step(s, 0);
    for (int k = 1; k < n; k++) begin
      s = s | ((scat_tab[3*(k-1)] - (s & scat_tab[3*(k-1)+1])) & scat_tab[3*(k-1)+2]);
      s = propagate_step(s, k);
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic apply_request(in_item_t r);
    out_item_t e;
    case (r.kind)
      KIND_WRITE: begin
        if (r.table_select == SEL_CHAR) sym_tab[r.table_row] = r.table_word;
        else if (r.table_select == SEL_LOOP) loop_tab[r.table_row] = r.table_word;
        else if (r.table_select <= SEL_BACK_BLK && r.table_row < NLV) begin
          case (r.table_select)
            SEL_GATH_BLK, SEL_GATH_SRC, SEL_GATH_DST:
              gath_tab[3*r.table_row + r.table_select - SEL_GATH_BLK] = r.table_word;
            SEL_SCAT_BLK, SEL_SCAT_SRC, SEL_SCAT_DST:
              scat_tab[3*r.table_row + r.table_select - SEL_SCAT_BLK] = r.table_word;
            SEL_PROP_BLK, SEL_PROP_SRC, SEL_PROP_DST:
              prop_tab[3*r.table_row + r.table_select - SEL_PROP_BLK] = r.table_word;
            SEL_BACK_SRC: bsrc_tab[r.table_row] = r.table_word;
            SEL_BACK_DST: bdst_tab[r.table_row] = r.table_word;
            default:
              if (r.shift_level < NSH) bblk_tab[r.table_row*NSH + r.shift_level] = r.table_word;
          endcase
        end
      end
      KIND_START: begin
        nfa_states = epsilon_closure(64'd1);
        text_pos = 0;
        e.matched = nfa_states[accept_bit];
        e.position = text_pos;
        match_queue.insert(match_queue.size(), e);
      end
      KIND_SYMBOL: begin
        nfa_states = ((nfa_states << 1) & sym_tab[r.symbol]) | 64'd1
                     | (nfa_states & loop_tab[r.symbol]);
        nfa_states = epsilon_closure(nfa_states);
        if (text_pos != 32'hFFFF_FFFF) text_pos++;
        e.matched = nfa_states[accept_bit];
        e.position = text_pos;
        match_queue.insert(match_queue.size(), e);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      levels_reg <= 1;
      accept_bit <= 63;
      nfa_states = 0;
      text_pos = 0;
      fail_count = 0;
      match_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LEVEL_COUNT) levels_reg <= cfg_data[3:0];
        else accept_bit <= cfg_data;
      end
      if (in_valid && in_ready) apply_request(in_data);
      if (out_valid && out_ready) begin
        if (match_queue.size() == 0) begin
          report_mismatch("result with no request waiting", 64'd1, 64'd0);
        end else begin
          e = match_queue.pop_front();
          if (out_data.matched !== e.matched)
            report_mismatch("matched", out_data.matched, e.matched);
          if (out_data.position !== e.position)
            report_mismatch("position", out_data.position, e.position);
        end
      end
    end
  end
endmodule

// ===== test/tb.sv =====
// Top of the NFA matcher testbench: clock, reset, configuration, requests and
// result back-pressure. Depends on bpnm_pkg, nfa_match_checker and the block.
`timescale 1ns / 1ps
module tb;
  import bpnm_pkg::*;

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  in_item_t   in_data;
  out_item_t  out_data;
  logic       cfg_we, cfg_index;
  logic [5:0] cfg_data;
  int         fail_count, pending_count;
  int         stall_mode;  // 0 random idling, 1 none, 2 long hold-off

  bit_parallel_nfa_matcher dut (.*);
  nfa_match_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver side: random stalls, or a long hold-off counted in cycles here.
  initial begin
    int held;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (stall_mode == 2) begin
        out_ready <= 0;
        held = 0;
        while (held < 400) begin
          @(posedge clk);
          held++;
        end
        stall_mode = 0;
      end else
        out_ready <= (stall_mode == 1) || ($urandom_range(99) >= 28);
    end
  end

  task automatic send_request(in_item_t r);
    if (stall_mode == 0)
      while ($urandom_range(99) < 28) begin
        in_valid <= 0;
        @(posedge clk);
      end
    in_valid <= 1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_write(logic [3:0] sel, logic [7:0] row, logic [2:0] step,
                            logic [63:0] word);
    in_item_t r;
    r = '{kind: KIND_WRITE, table_select: sel, table_row: row, shift_level: step,
          table_word: word, symbol: 8'($urandom)};
    send_request(r);
  endtask

  task automatic send_text(logic [1:0] k, logic [7:0] sym);
    in_item_t r;
    r = '{kind: k, table_select: 4'($urandom), table_row: 8'($urandom),
          shift_level: 3'($urandom), table_word: {$urandom, $urandom}, symbol: sym};
    send_request(r);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  // Quiesce, then write one configuration register.
  task automatic set_register(logic idx, logic [5:0] val);
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic load_all_tables();
    for (int s = 0; s < 256; s++) begin
      send_write(SEL_CHAR, 8'(s), 3'd0, rand_word());
      send_write(SEL_LOOP, 8'(s), 3'd0, rand_word());
    end
    for (int lv = 0; lv < MAX_LEVELS_DEF; lv++) begin
      for (int sel = SEL_GATH_BLK; sel <= SEL_BACK_DST; sel++)
        send_write(4'(sel), 8'(lv), 3'd0, rand_word());
      for (int st = 0; st < SHIFT_STEPS_DEF; st++)
        send_write(SEL_BACK_BLK, 8'(lv), 3'(st), rand_word());
    end
  endtask

  initial begin
    int lvls [6];
    lvls = '{1, 8, 0, 15, 3, 5};
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    stall_mode = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    stall_mode = 0;
    load_all_tables();
    // Directed: ignored kinds, bad selects and rows, extreme symbols.
    send_text(KIND_START, 8'h00);
    send_text(KIND_SYMBOL, 8'h00);
    send_text(KIND_SYMBOL, 8'hFF);
    send_text(KIND_RESERVED, 8'h55);
    send_write(4'd14, 8'd0, 3'd0, '1);
    send_write(4'd15, 8'd0, 3'd0, '1);
    send_write(SEL_PROP_BLK, 8'd8, 3'd0, '1);
    send_write(SEL_GATH_DST, 8'd255, 3'd0, '1);
    send_write(SEL_BACK_BLK, 8'd0, 3'd6, '1);
    send_write(SEL_BACK_BLK, 8'd7, 3'd7, '1);
    send_write(SEL_CHAR, 8'd255, 3'd0, '1);
    send_write(SEL_LOOP, 8'd0, 3'd0, '0);
    send_text(KIND_SYMBOL, 8'hFF);
    for (int ph = 0; ph < 6; ph++) begin
      set_register(CFG_LEVEL_COUNT, 6'(lvls[ph]));
      set_register(CFG_ACCEPT_INDEX, ph == 0 ? 6'd0 : (ph == 1 ? 6'd63 : 6'($urandom)));
      stall_mode = (ph == 2) ? 1 : 0;
      for (int n = 0; n < 100; n++) begin
        if (ph == 3 && n == 20) stall_mode = 2;
        case ($urandom_range(19))
          0: send_text(KIND_START, 8'($urandom));
          1: send_write(4'($urandom_range(13)), 8'($urandom_range(9)),
                        3'($urandom_range(7)), rand_word());
          2: send_text(KIND_RESERVED, 8'($urandom));
          default: send_text(KIND_SYMBOL, ($urandom_range(1) ? 8'($urandom_range(7))
                                                              : 8'($urandom)));
        endcase
      end
    end
    in_valid <= 0;
    stall_mode = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
